// ----- sv/cmap4_pkg.sv -----
// ----------------------------------------------------------------------------
// cmap4_pkg
// shared types and constants of the format 4 segment builder
// ----------------------------------------------------------------------------
package cmap4_pkg;

  // default longest run kept in one segment
  localparam int unsigned RUN_DEPTH_DEF = 32;

  // terminator segment fields
  localparam logic [15:0] TERM_CODE  = 16'hFFFF;
  localparam logic [15:0] TERM_DELTA = 16'd1;

  typedef enum logic [1:0] {
    KIND_SEG  = 2'd0,
    KIND_WORD = 2'd1,
    KIND_TERM = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEG,
    ST_WORD,
    ST_TERM
  } state_e;

  // one result item
  typedef struct packed {
    kind_e       kind;
    logic [15:0] start_code;
    logic [15:0] end_code;
    logic [15:0] delta;
    logic        uses_array;
    logic [15:0] segment_index;
    logic [16:0] array_base;
    logic [15:0] array_word;
    logic        end_of_burst;
  } res_t;

endpackage

// ----- sv/cmap4_glyph_ram.sv -----
// ----------------------------------------------------------------------------
// cmap4_glyph_ram
// glyph buffer of the open run, one write and one registered read port
// ----------------------------------------------------------------------------
module cmap4_glyph_ram #(
  parameter int unsigned Depth = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [15:0]                            wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [15:0]                            rdata_o
);

  logic [15:0] mem [Depth];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/cmap4_ctrl.sv -----
// ----------------------------------------------------------------------------
// cmap4_ctrl
// run tracking, segment close sequencer and glyph buffer access
// ----------------------------------------------------------------------------
module cmap4_ctrl import cmap4_pkg::*; #(
  parameter int unsigned RunDepth = RUN_DEPTH_DEF,
  localparam int unsigned AW = (RunDepth > 1) ? $clog2(RunDepth) : 1,
  localparam int unsigned LW = $clog2(RunDepth + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [15:0]   code_i,
  input  logic [15:0]   glyph_i,
  input  logic          last_i,
  input  logic          slot_free_i,
  output logic          emit_o,
  output res_t          res_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [15:0]   mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [15:0]   mem_rdata_i
);

  state_e        state_q, state_d;
  logic          have_run_q, have_run_d;
  logic [15:0]   run_start_q, run_start_d;
  logic [15:0]   run_end_q, run_end_d;
  logic [15:0]   run_delta_q, run_delta_d;
  logic          mismatch_q, mismatch_d;
  logic [LW-1:0] run_len_q, run_len_d;
  logic [15:0]   seg_cnt_q, seg_cnt_d;
  logic [16:0]   arr_total_q, arr_total_d;
  logic [15:0]   code_q, code_d;
  logic [15:0]   glyph_q, glyph_d;
  logic          last_q, last_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] idx_q, idx_d;

  logic          extend;
  logic          close_fin;
  logic          start_run;
  logic [15:0]   st_code;
  logic [15:0]   st_glyph;
  logic [LW-1:0] nxt_idx;

  assign extend = have_run_q
                  && ({1'b0, code_i} == ({1'b0, run_end_q} + 17'd1))
                  && (run_len_q < LW'(RunDepth));
  assign nxt_idx = LW'(idx_q) + LW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_run_q  <= 1'b0;
      run_start_q <= '0;
      run_end_q   <= '0;
      run_delta_q <= '0;
      mismatch_q  <= 1'b0;
      run_len_q   <= '0;
      seg_cnt_q   <= '0;
      arr_total_q <= '0;
      last_q      <= 1'b0;
      pend_q      <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      have_run_q  <= have_run_d;
      run_start_q <= run_start_d;
      run_end_q   <= run_end_d;
      run_delta_q <= run_delta_d;
      mismatch_q  <= mismatch_d;
      run_len_q   <= run_len_d;
      seg_cnt_q   <= seg_cnt_d;
      arr_total_q <= arr_total_d;
      last_q      <= last_d;
      pend_q      <= pend_d;
      idx_q       <= idx_d;
    end
  end

  // pending pair, payload only
  always_ff @(posedge clk_i) begin
    code_q  <= code_d;
    glyph_q <= glyph_d;
  end

  always_comb begin
    state_d     = state_q;
    have_run_d  = have_run_q;
    run_start_d = run_start_q;
    run_end_d   = run_end_q;
    run_delta_d = run_delta_q;
    mismatch_d  = mismatch_q;
    run_len_d   = run_len_q;
    seg_cnt_d   = seg_cnt_q;
    arr_total_d = arr_total_q;
    code_d      = code_q;
    glyph_d     = glyph_q;
    last_d      = last_q;
    pend_d      = pend_q;
    idx_d       = idx_q;

    in_ready_o  = (state_q == ST_IDLE);
    emit_o      = 1'b0;
    res_o       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = glyph_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    close_fin   = 1'b0;
    start_run   = 1'b0;
    st_code     = code_i;
    st_glyph    = glyph_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          code_d  = code_i;
          glyph_d = glyph_i;
          last_d  = last_i;
          if (extend) begin
            run_end_d   = code_i;
            mem_we_o    = 1'b1;
            mem_waddr_o = run_len_q[AW-1:0];
            mem_wdata_o = glyph_i;
            if (glyph_i != (code_i + run_delta_q)) begin
              mismatch_d = 1'b1;
            end
            run_len_d = run_len_q + LW'(1);
            if (last_i) begin
              state_d = ST_SEG;
            end
          end else if (have_run_q) begin
            // old run must drain before the new glyph lands in entry zero
            pend_d  = 1'b1;
            state_d = ST_SEG;
          end else begin
            start_run = 1'b1;
            if (last_i) begin
              state_d = ST_SEG;
            end
          end
        end
      end
      ST_SEG: begin
        if (slot_free_i) begin
          emit_o                = 1'b1;
          res_o.kind            = KIND_SEG;
          res_o.start_code      = run_start_q;
          res_o.end_code        = run_end_q;
          res_o.delta           = run_delta_q;
          res_o.uses_array      = mismatch_q;
          res_o.segment_index   = seg_cnt_q;
          res_o.array_base      = arr_total_q;
          res_o.end_of_burst    = !mismatch_q && !last_q;
          if (mismatch_q) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = '0;
            idx_d       = '0;
            state_d     = ST_WORD;
          end else begin
            close_fin = 1'b1;
          end
        end
      end
      ST_WORD: begin
        if (slot_free_i) begin
          emit_o             = 1'b1;
          res_o.kind         = KIND_WORD;
          res_o.array_word   = mem_rdata_i;
          res_o.end_of_burst = (nxt_idx == run_len_q) && !last_q;
          if (nxt_idx < run_len_q) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = nxt_idx[AW-1:0];
            idx_d       = nxt_idx[AW-1:0];
          end else begin
            close_fin = 1'b1;
          end
        end
      end
      ST_TERM: begin
        if (slot_free_i) begin
          emit_o              = 1'b1;
          res_o.kind          = KIND_TERM;
          res_o.start_code    = TERM_CODE;
          res_o.end_code      = TERM_CODE;
          res_o.delta         = TERM_DELTA;
          res_o.segment_index = seg_cnt_q;
          res_o.array_base    = arr_total_q;
          res_o.end_of_burst  = 1'b1;
          seg_cnt_d           = '0;
          arr_total_d         = '0;
          run_start_d         = '0;
          run_end_d           = '0;
          run_delta_d         = '0;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // segment fully emitted
    if (close_fin) begin
      if (mismatch_q) begin
        arr_total_d = arr_total_q + 17'(run_len_q);
      end
      seg_cnt_d  = seg_cnt_q + 16'd1;
      have_run_d = 1'b0;
      run_len_d  = '0;
      mismatch_d = 1'b0;
      if (pend_q) begin
        pend_d    = 1'b0;
        start_run = 1'b1;
        st_code   = code_q;
        st_glyph  = glyph_q;
        state_d   = last_q ? ST_SEG : ST_IDLE;
      end else begin
        state_d = ST_TERM;
      end
    end

    // open a run with one glyph
    if (start_run) begin
      have_run_d  = 1'b1;
      run_start_d = st_code;
      run_end_d   = st_code;
      run_delta_d = st_glyph - st_code;
      mismatch_d  = 1'b0;
      run_len_d   = LW'(1);
      mem_we_o    = 1'b1;
      mem_waddr_o = '0;
      mem_wdata_o = st_glyph;
    end
  end

endmodule

// ----- sv/cmap_format4_segment_builder.sv -----
// ----------------------------------------------------------------------------
// cmap_format4_segment_builder
// groups ascending (code, glyph) pairs into format 4 segments
// ----------------------------------------------------------------------------
// a pair that extends the open run is taken while idle and gives no result
// a closing pair holds the input until the sequencer has emitted every result
//   item: the record, one per glyph word, and on a last pair that starts a new
//   run both segments plus the terminator; each item shows in the cycle after
// throughput bound by the single read port of the glyph buffer, one word a cycle unless the output stalls
// reset: control and counters cleared at once, glyph buffer not cleared
module cmap_format4_segment_builder import cmap4_pkg::*; #(
  parameter int unsigned RUN_DEPTH = RUN_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_i,
  input  logic [15:0] glyph_i,
  input  logic        last_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [15:0] start_code_o,
  output logic [15:0] end_code_o,
  output logic [15:0] delta_o,
  output logic        uses_array_o,
  output logic [15:0] segment_index_o,
  output logic [16:0] array_base_o,
  output logic [15:0] array_word_o,
  output logic        end_of_burst_o
);

  localparam int unsigned AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;

  logic          slot_free;
  logic          emit;
  res_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  logic          out_valid_q, out_valid_d;
  res_t          res_q;

  // run state and close sequencer
  cmap4_ctrl #(
    .RunDepth (RUN_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .code_i      (code_i),
    .glyph_i     (glyph_i),
    .last_i      (last_i),
    .slot_free_i (slot_free),
    .emit_o      (emit),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // glyphs of the open run, drained when an array segment closes
  cmap4_glyph_ram #(
    .Depth (RUN_DEPTH)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register: sequencer may load it whenever it is empty or being taken
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_d = emit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = res_q.kind;
  assign start_code_o    = res_q.start_code;
  assign end_code_o      = res_q.end_code;
  assign delta_o         = res_q.delta;
  assign uses_array_o    = res_q.uses_array;
  assign segment_index_o = res_q.segment_index;
  assign array_base_o    = res_q.array_base;
  assign array_word_o    = res_q.array_word;
  assign end_of_burst_o  = res_q.end_of_burst;

endmodule

// ----- sim/cmap4_segment_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmap4_segment_checker
// watches both channels of the segment builder, works out the segment
// records, glyph words and terminators each pair should cause, and checks
// every result item field by field in order
// ----------------------------------------------------------------------------
module cmap4_segment_checker import cmap4_pkg::*; #(
  parameter int unsigned RUN_DEPTH = RUN_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] code_i,
  input  logic [15:0] glyph_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [15:0] start_code_i,
  input  logic [15:0] end_code_i,
  input  logic [15:0] delta_i,
  input  logic        uses_array_i,
  input  logic [15:0] segment_index_i,
  input  logic [16:0] array_base_i,
  input  logic [15:0] array_word_i,
  input  logic        end_of_burst_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // open run and set counters
  bit          run_open;
  logic [15:0] run_first;
  logic [15:0] run_last;
  logic [15:0] run_delta;
  bit          run_has_array;
  int unsigned run_len;
  logic [15:0] run_glyph_buf [RUN_DEPTH];
  logic [15:0] seg_count;
  logic [16:0] words_emitted;

  // records still owed by the block, oldest first
  res_t segment_records [$];
  res_t held_rec;
  bit   have_held;

  task automatic report_mismatch(input string what, input logic [16:0] got,
                                 input logic [16:0] want);
    if (fail_count_o < 100) begin
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    end
    fail_count_o++;
  endtask

  // hold back one record so the last of a burst can get its end mark
  task automatic emit_record(input res_t rec);
    if (have_held) begin
      segment_records = {segment_records, held_rec};
    end
    held_rec  = rec;
    have_held = 1'b1;
  endtask

  task automatic close_open_run();
    res_t rec;
    if (run_open) begin
      rec            = '0;
      rec.kind       = KIND_SEG;
      rec.start_code = run_first;
      rec.end_code   = run_last;
      rec.delta      = run_delta;
      rec.uses_array = run_has_array;
      rec.segment_index = seg_count;
      rec.array_base = words_emitted;
      emit_record(rec);
      if (run_has_array) begin
        for (int i = 0; i < run_len; i++) begin
          rec            = '0;
          rec.kind       = KIND_WORD;
          rec.array_word = run_glyph_buf[i];
          emit_record(rec);
        end
        words_emitted = words_emitted + 17'(run_len);
      end
      seg_count     = seg_count + 16'd1;
      run_open      = 1'b0;
      run_len       = 0;
      run_has_array = 1'b0;
    end
  endtask

  task automatic predict_pair(input logic [15:0] code, input logic [15:0] glyph,
                              input logic last_pair);
    res_t rec;
    // no wrap past 0xffff when testing for the next consecutive code
    if (run_open && ({1'b0, code} == {1'b0, run_last} + 17'd1) &&
        run_len < RUN_DEPTH) begin
      run_last               = code;
      run_glyph_buf[run_len] = glyph;
      if (glyph != 16'(code + run_delta)) begin
        run_has_array = 1'b1;
      end
      run_len++;
    end else begin
      close_open_run();
      run_open         = 1'b1;
      run_first        = code;
      run_last         = code;
      run_delta        = glyph - code;
      run_has_array    = 1'b0;
      run_glyph_buf[0] = glyph;
      run_len          = 1;
    end
    if (last_pair) begin
      close_open_run();
      rec               = '0;
      rec.kind          = KIND_TERM;
      rec.start_code    = TERM_CODE;
      rec.end_code      = TERM_CODE;
      rec.delta         = TERM_DELTA;
      rec.segment_index = seg_count;
      rec.array_base    = words_emitted;
      emit_record(rec);
      seg_count     = '0;
      words_emitted = '0;
      run_first     = '0;
      run_last      = '0;
      run_delta     = '0;
    end
    if (have_held) begin
      held_rec.end_of_burst = 1'b1;
      segment_records = {segment_records, held_rec};
      have_held = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      run_open      = 1'b0;
      run_first     = '0;
      run_last      = '0;
      run_delta     = '0;
      run_has_array = 1'b0;
      run_len       = 0;
      seg_count     = '0;
      words_emitted = '0;
      have_held     = 1'b0;
      segment_records.delete();
    end else begin
      // input first, in case a result leaves in the cycle its pair is taken
      if (in_valid_i && in_ready_i) begin
        predict_pair(code_i, glyph_i, last_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (segment_records.size() == 0) begin
          report_mismatch("unexpected item, kind", 17'(kind_i), '0);
        end else begin
          want = segment_records.pop_front();
          if (kind_i != want.kind)
            report_mismatch("kind", 17'(kind_i), 17'(want.kind));
          if (start_code_i != want.start_code)
            report_mismatch("start_code", 17'(start_code_i), 17'(want.start_code));
          if (end_code_i != want.end_code)
            report_mismatch("end_code", 17'(end_code_i), 17'(want.end_code));
          if (delta_i != want.delta)
            report_mismatch("delta", 17'(delta_i), 17'(want.delta));
          if (uses_array_i != want.uses_array)
            report_mismatch("uses_array", 17'(uses_array_i), 17'(want.uses_array));
          if (segment_index_i != want.segment_index)
            report_mismatch("segment_index", 17'(segment_index_i),
                            17'(want.segment_index));
          if (array_base_i != want.array_base)
            report_mismatch("array_base", array_base_i, want.array_base);
          if (array_word_i != want.array_word)
            report_mismatch("array_word", 17'(array_word_i), 17'(want.array_word));
          if (end_of_burst_i != want.end_of_burst)
            report_mismatch("end_of_burst", 17'(end_of_burst_i),
                            17'(want.end_of_burst));
        end
      end
    end
    pending_o = segment_records.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// feeds the format 4 segment builder with directed and random (code, glyph)
// sets under three idling mixes and reports the checker's verdict
// ----------------------------------------------------------------------------
module tb_top import cmap4_pkg::*; ();

  localparam int unsigned RUN_DEPTH = RUN_DEPTH_DEF;
  // random pairs per idling mix, about 400 items over the whole run
  localparam int unsigned PAIRS_PER_MIX = 130;

  // all inputs known from time zero
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [15:0] code_in    = '0;
  logic [15:0] glyph_in   = '0;
  logic        last_in    = 1'b0;
  logic        out_ready  = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic [1:0]  kind;
  logic [15:0] start_code;
  logic [15:0] end_code;
  logic [15:0] delta;
  logic        uses_array;
  logic [15:0] segment_index;
  logic [16:0] array_base;
  logic [15:0] array_word;
  logic        end_of_burst;

  int unsigned fail_count;
  int unsigned records_pending;

  // idle chance in percent for each side
  int unsigned send_idle_pct = 8;
  int unsigned take_idle_pct = 74;
  int unsigned pairs_sent    = 0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cmap_format4_segment_builder #(
    .RUN_DEPTH (RUN_DEPTH)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .code_i          (code_in),
    .glyph_i         (glyph_in),
    .last_i          (last_in),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .kind_o          (kind),
    .start_code_o    (start_code),
    .end_code_o      (end_code),
    .delta_o         (delta),
    .uses_array_o    (uses_array),
    .segment_index_o (segment_index),
    .array_base_o    (array_base),
    .array_word_o    (array_word),
    .end_of_burst_o  (end_of_burst)
  );

  cmap4_segment_checker #(
    .RUN_DEPTH (RUN_DEPTH)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .code_i          (code_in),
    .glyph_i         (glyph_in),
    .last_i          (last_in),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .kind_i          (kind),
    .start_code_i    (start_code),
    .end_code_i      (end_code),
    .delta_i         (delta),
    .uses_array_i    (uses_array),
    .segment_index_i (segment_index),
    .array_base_i    (array_base),
    .array_word_i    (array_word),
    .end_of_burst_i  (end_of_burst),
    .fail_count_o    (fail_count),
    .pending_o       (records_pending)
  );

  // receiver stalls at random, one draw per cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= take_idle_pct);
  end

  // offer one item; returns in the step of the edge that took it, so the
  // next call may change the payload without dropping valid
  task automatic send_pair(input logic [15:0] c, input logic [15:0] g,
                           input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    code_in  <= c;
    glyph_in <= g;
    last_in  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pairs_sent++;
  endtask

  // one well formed set: ascending runs with random content, last on the end
  // a few sets leave last off so the next set may start below the open run
  task automatic send_font_set();
    int unsigned n_runs;
    int unsigned lens [6];
    int unsigned gaps [6];
    int unsigned span;
    int unsigned c;
    int unsigned glyph_mode;
    int unsigned bad_pos;
    logic [15:0] run_off;
    logic [15:0] g;
    bit          close_set;
    n_runs    = $urandom_range(1, 6);
    close_set = ($urandom_range(9) != 0);
    span      = 0;
    for (int r = 0; r < n_runs; r++) begin
      // now and then a run from one below to three past the buffer depth, so it may get split
      if ($urandom_range(7) == 0) begin
        lens[r] = RUN_DEPTH + $urandom_range(4) - 1;
        if (lens[r] == 0) lens[r] = 1;
      end else begin
        lens[r] = $urandom_range(1, 6);
      end
      // gap of one merges two runs into one
      if (r == 0) gaps[r] = 0;
      else if ($urandom_range(3) == 0) gaps[r] = $urandom_range(2, 3000);
      else gaps[r] = $urandom_range(1, 4);
      span += lens[r] - 1 + gaps[r];
    end
    // some sets end right on code 0xffff
    if ($urandom_range(7) == 0) c = 65535 - span;
    else c = $urandom_range(0, 65535 - span);
    for (int r = 0; r < n_runs; r++) begin
      c += gaps[r];
      run_off    = 16'($urandom());
      glyph_mode = $urandom_range(2);
      bad_pos    = $urandom_range(lens[r] - 1);
      for (int i = 0; i < lens[r]; i++) begin
        g = 16'(c + i) + run_off;
        // mode 1: a single glyph off the delta, mode 2: glyphs all over
        if (glyph_mode == 1 && i == bad_pos) g = g + 16'($urandom_range(1, 65535));
        if (glyph_mode == 2) g = 16'($urandom());
        send_pair(16'(c + i), g,
                  close_set && r == n_runs - 1 && i == lens[r] - 1);
      end
      c += lens[r] - 1;
    end
  endtask

  // noise: unordered pairs with random last
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      send_pair(16'($urandom()), 16'($urandom()), ($urandom_range(2) == 0));
    end
  endtask

  task automatic run_random(input int unsigned upto);
    while (pairs_sent < upto) begin
      if ($urandom_range(7) == 0) send_noise();
      else send_font_set();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // delta zero run that turns into an array segment on its third glyph
    send_pair(16'h0000, 16'h0000, 1'b0);
    send_pair(16'h0001, 16'h0001, 1'b0);
    send_pair(16'h0002, 16'hFFFF, 1'b0);
    // jump ahead: closes the array segment, drains its three words
    send_pair(16'h0010, 16'h1234, 1'b0);
    send_pair(16'h0011, 16'h1235, 1'b0);
    // code going backward closes the open run and opens a new one
    send_pair(16'h0005, 16'h0000, 1'b0);
    // run up to code 0xffff with a wrapping delta, ends the set
    send_pair(16'hFFFE, 16'hFFFF, 1'b0);
    send_pair(16'hFFFF, 16'h0000, 1'b1);
    // single pair sets, one of them at the top code
    send_pair(16'h8000, 16'h7FFF, 1'b1);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1);
    // last on a pair that extends the run
    send_pair(16'h7FFF, 16'h8000, 1'b0);
    send_pair(16'h8000, 16'h8001, 1'b1);
    // all ones glyph on code 0x00ff, then back down to zero
    send_pair(16'h00FF, 16'hFFFF, 1'b0);
    send_pair(16'h0100, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'h5555, 1'b0);
    send_pair(16'h0001, 16'hAAAA, 1'b1);

    // sender mostly busy, receiver mostly stalled
    run_random(pairs_sent + PAIRS_PER_MIX);
    // sender gappy, receiver eager
    send_idle_pct = 74;
    take_idle_pct = 8;
    run_random(pairs_sent + PAIRS_PER_MIX);
    // full rate both sides
    send_idle_pct = 0;
    take_idle_pct = 0;
    run_random(pairs_sent + PAIRS_PER_MIX);
    in_valid <= 1'b0;

    // drain what is owed, then give stray items a chance to show up
    @(negedge clk);
    while (records_pending != 0) @(negedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // slowest correct run is far below this
  initial begin
    #24_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/cmap4_pkg.sv
sv/cmap4_glyph_ram.sv
sv/cmap4_ctrl.sv
sv/cmap_format4_segment_builder.sv
sim/cmap4_segment_checker.sv
sim/tb_top.sv
